@@ hdl/lpfc_pkg.sv @@
// Shared types and constants for the length-prefixed frame checker.
package lpfc_pkg;

  // Item kinds on the input channel
  typedef enum logic {
    MODE_BYTE = 1'b0,
    MODE_TICK = 1'b1
  } mode_t;

  // Frame outcome codes
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_NO_DATA = 2'd1,
    ST_TIMEOUT = 2'd2,
    ST_BAD_SUM = 2'd3
  } status_t;

  localparam logic [7:0]  TICKS_PER_BYTE_RESET = 8'd16;
  localparam logic [7:0]  EMPTY_LENGTH         = 8'h00;
  localparam logic [7:0]  SINGLE_LENGTH        = 8'h01;
  localparam logic [15:0] TICK_COUNT_MAX       = 16'hFFFF;

  // Frame tracking state
  typedef struct packed {
    logic        receiving;
    logic [7:0]  expected_length;
    logic [7:0]  bytes_seen;
    logic [7:0]  running_sum;
    logic [15:0] tick_count;
    logic [15:0] time_limit;
  } frame_state_t;

  // Outcome of one word
  typedef struct packed {
    logic       emit;
    status_t    status;
    logic [7:0] frame_length;
  } frame_result_t;

endpackage

@@ hdl/lpfc_if.sv @@
// Valid/ready channel interfaces for input words and frame results.
interface lpfc_item_if;
  logic       valid;
  logic       ready;
  logic       mode;
  logic [7:0] byte_value;

  modport source (output valid, output mode, output byte_value, input ready);
  modport sink (input valid, input mode, input byte_value, output ready);
endinterface

interface lpfc_result_if;
  logic       valid;
  logic       ready;
  logic [1:0] status;
  logic [7:0] frame_length;

  modport source (output valid, output status, output frame_length, input ready);
  modport sink (input valid, input status, input frame_length, output ready);
endinterface

@@ hdl/lpfc_step.sv @@
// Next-state and outcome logic for one input word of the frame checker.
module lpfc_step
  import lpfc_pkg::*;
(
  input  frame_state_t  state,
  input  logic          mode,
  input  logic [7:0]    byte_value,
  input  logic [7:0]    ticks_per_byte,
  output frame_state_t  state_next,
  output frame_result_t result
);

  logic [15:0] tick_inc;
  logic [7:0]  seen_inc;

  // Saturating tick count and next byte count for the open frame
  assign tick_inc = (state.tick_count != TICK_COUNT_MAX) ?
                    state.tick_count + 16'd1 : state.tick_count;
  assign seen_inc = state.bytes_seen + 8'd1;

  always_comb begin
    state_next          = state;
    result.emit         = 1'b0;
    result.status       = ST_OK;
    result.frame_length = state.expected_length;

    if (mode_t'(mode) == MODE_TICK) begin
      // Count ticks while a frame is open; end it past the limit
      if (state.receiving) begin
        state_next.tick_count = tick_inc;
        if (tick_inc > state.time_limit) begin
          result.emit          = 1'b1;
          result.status        = ST_TIMEOUT;
          state_next.receiving = 1'b0;
        end
      end
    end else if (!state.receiving) begin
      // Length word: zero reports no data, one a bad sum, else it opens a frame
      if (byte_value == EMPTY_LENGTH) begin
        result.emit         = 1'b1;
        result.status       = ST_NO_DATA;
        result.frame_length = EMPTY_LENGTH;
      end else begin
        state_next.expected_length = byte_value;
        state_next.bytes_seen      = 8'd1;
        state_next.running_sum     = byte_value;
        state_next.tick_count      = 16'd0;
        state_next.time_limit      = 16'(ticks_per_byte) * 16'(byte_value);
        if (byte_value == SINGLE_LENGTH) begin
          result.emit         = 1'b1;
          result.status       = ST_BAD_SUM;
          result.frame_length = SINGLE_LENGTH;
        end else begin
          state_next.receiving = 1'b1;
        end
      end
    end else begin
      // Accumulate body words; check the last one against the sum
      state_next.bytes_seen = seen_inc;
      if (seen_inc >= state.expected_length) begin
        result.emit          = 1'b1;
        result.status        = (state.running_sum == byte_value) ? ST_OK : ST_BAD_SUM;
        state_next.receiving = 1'b0;
      end else begin
        state_next.running_sum = state.running_sum + byte_value;
      end
    end
  end

endmodule

@@ hdl/length_prefixed_frame_checker_core.sv @@
// Top level of the length-prefixed frame checker with additive checksum.
// Takes one word per clock while ready (a received byte or a timer tick) and
// yields at most one frame result per word, registered in the cycle after the
// word is accepted. The frame state is updated in the cycle a word is taken,
// and the result lands in a single output register; the item channel is
// ready whenever that register is empty or is being read in the same cycle,
// so with a ready consumer the sustained rate is one word per cycle.
// ticks_per_byte resets to 16 and applies from the next frame that opens.
module length_prefixed_frame_checker_core
  import lpfc_pkg::*;
(
  input  logic          clk,
  input  logic          rst,
  lpfc_item_if.sink     item,
  lpfc_result_if.source result,
  input  logic          cfg_write_en,
  input  logic [7:0]    cfg_write_data
);

  frame_state_t  state;
  frame_state_t  state_next;
  frame_result_t step_result;
  logic [7:0]    ticks_per_byte;
  logic          out_valid;
  status_t       out_status;
  logic [7:0]    out_length;
  logic          item_take;
  logic          res_load;

  // Take a word whenever the result register is free or draining
  assign item.ready = !out_valid || result.ready;
  assign item_take  = item.valid && item.ready;
  assign res_load   = item_take && step_result.emit;

  lpfc_step u_step (
    .state          (state),
    .mode           (item.mode),
    .byte_value     (item.byte_value),
    .ticks_per_byte (ticks_per_byte),
    .state_next     (state_next),
    .result         (step_result)
  );

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      ticks_per_byte <= TICKS_PER_BYTE_RESET;
    end else if (cfg_write_en) begin
      ticks_per_byte <= cfg_write_data;
    end
  end

  // Advance frame state on each accepted word
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= '0;
    end else if (item_take) begin
      state <= state_next;
    end
  end

  // Result register: load a new outcome, drop it once taken
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_load) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      out_status <= step_result.status;
      out_length <= step_result.frame_length;
    end
  end

  assign result.valid        = out_valid;
  assign result.status       = out_status;
  assign result.frame_length = out_length;

`ifndef SYNTH
  // An open frame always expects a length byte and a checksum byte
  a_open_len: assert property (@(posedge clk) disable iff (rst)
    state.receiving |-> state.expected_length >= 8'd2)
    else $error("open frame with length below two");

  // The byte count never reaches the length while the frame is open
  a_open_count: assert property (@(posedge clk) disable iff (rst)
    state.receiving |-> state.bytes_seen < state.expected_length)
    else $error("open frame has seen all its bytes");

  // An open frame never sits past its time limit
  a_open_time: assert property (@(posedge clk) disable iff (rst)
    state.receiving |-> state.tick_count <= state.time_limit)
    else $error("open frame past its time limit");

  // A zero length byte while idle reports no data on the next cycle
  a_no_data: assert property (@(posedge clk) disable iff (rst)
    (item_take && !item.mode && !state.receiving && item.byte_value == EMPTY_LENGTH)
    |=> (result.valid && result.status == ST_NO_DATA &&
         result.frame_length == EMPTY_LENGTH))
    else $error("zero length byte did not report no data");
`endif

endmodule

@@ test/frame_outcome_checker.sv @@
`timescale 1ns / 1ps
// Frame outcome checker: watches both channels, predicts each outcome and compares it.
module frame_outcome_checker
  import lpfc_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       item_valid,
  input  logic       item_ready,
  input  logic       item_mode,
  input  logic [7:0] item_byte,
  input  logic       result_valid,
  input  logic       result_ready,
  input  logic [1:0] result_status,
  input  logic [7:0] result_length,
  input  logic       cfg_write_en,
  input  logic [7:0] cfg_write_data,
  output int         mismatch_count,
  output int         outcomes_pending,
  output int         outcomes_checked
);

  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    status_t    status;
    logic [7:0] frame_length;
  } outcome_t;

  outcome_t     expected_outcomes[$];
  logic [7:0]   ticks_per_byte;
  frame_state_t frame;

  initial begin
    mismatch_count   = 0;
    outcomes_pending = 0;
    outcomes_checked = 0;
    ticks_per_byte   = TICKS_PER_BYTE_RESET;
    frame            = '0;
  end

  // Advance the frame state by one word and report the outcome it ends, if any
  task automatic predict_outcome(input logic mode, input logic [7:0] b,
                                 output logic emit, output outcome_t res);
    emit = 1'b0;
    res  = '0;
    if (mode == MODE_TICK) begin
      // Ticks only matter while a frame is open
      if (frame.receiving) begin
        if (frame.tick_count != TICK_COUNT_MAX) begin
          frame.tick_count = frame.tick_count + 16'd1;
        end
        if (frame.tick_count > frame.time_limit) begin
          emit             = 1'b1;
          res.status       = ST_TIMEOUT;
          res.frame_length = frame.expected_length;
          frame.receiving  = 1'b0;
        end
      end
    end else if (!frame.receiving) begin
      // Length word: zero reports no data, one a bad sum, else it opens a frame
      if (b == EMPTY_LENGTH) begin
        emit             = 1'b1;
        res.status       = ST_NO_DATA;
        res.frame_length = EMPTY_LENGTH;
      end else begin
        frame.expected_length = b;
        frame.bytes_seen      = 8'd1;
        frame.running_sum     = b;
        frame.tick_count      = '0;
        frame.time_limit      = {8'd0, ticks_per_byte} * {8'd0, b};
        if (b == SINGLE_LENGTH) begin
          // Length word doubles as checksum, which never matches
          emit             = 1'b1;
          res.status       = ST_BAD_SUM;
          res.frame_length = SINGLE_LENGTH;
        end else begin
          frame.receiving = 1'b1;
        end
      end
    end else begin
      frame.bytes_seen = frame.bytes_seen + 8'd1;
      if (frame.bytes_seen >= frame.expected_length) begin
        emit             = 1'b1;
        res.status       = (frame.running_sum == b) ? ST_OK : ST_BAD_SUM;
        res.frame_length = frame.expected_length;
        frame.receiving  = 1'b0;
      end else begin
        frame.running_sum = frame.running_sum + b;
      end
    end
  endtask

  always @(posedge clk) begin : watch
    logic     emit;
    outcome_t predicted;
    outcome_t oldest;
    if (rst) begin
      ticks_per_byte = TICKS_PER_BYTE_RESET;
      frame          = '0;
      expected_outcomes.delete();
    end else begin
      // Compare each delivered outcome with the oldest prediction
      if (result_valid && result_ready) begin
        outcomes_checked++;
        if (expected_outcomes.size() == 0) begin
          if (mismatch_count < REPORT_LIMIT) begin
            $display("%0t: unexpected outcome status %0d length %0d", $time,
                     result_status, result_length);
          end
          mismatch_count++;
        end else begin
          oldest = expected_outcomes.pop_front();
          if (result_status !== oldest.status ||
              result_length !== oldest.frame_length) begin
            if (mismatch_count < REPORT_LIMIT) begin
              $display({"%0t: outcome mismatch: expected status %0d length %0d, ",
                        "got status %0d length %0d"},
                       $time, oldest.status, oldest.frame_length, result_status,
                       result_length);
            end
            mismatch_count++;
          end
        end
      end
      // Predict from each accepted word, with the allowance held before this edge
      if (item_valid && item_ready) begin
        predict_outcome(item_mode, item_byte, emit, predicted);
        if (emit) begin
          expected_outcomes.push_back(predicted);
        end
      end
      // The register takes a write at this edge, for later words
      if (cfg_write_en) begin
        ticks_per_byte = cfg_write_data;
      end
    end
    outcomes_pending <= expected_outcomes.size();
  end

endmodule

@@ test/length_prefixed_frame_checker_core_tb.sv @@
`timescale 1ns / 1ps
// Testbench top for the frame checker: drives words and config, gives the verdict.
module length_prefixed_frame_checker_core_tb;
  import lpfc_pkg::*;

  localparam int RUN_CYCLE_LIMIT  = 400000;
  localparam int HOLD_CYCLES      = 300;
  localparam int WORDS_PER_PHASE  = 275;
  localparam int SETTLE_CYCLES    = 4;

  logic       clk;
  logic       rst;
  logic       cfg_write_en;
  logic [7:0] cfg_write_data;
  logic       hold_go;
  int         send_idle_pct;
  int         recv_idle_pct;
  int         words_sent;
  int         cfg_writes;
  int         cycle_count;
  int         mismatch_count;
  int         outcomes_pending;
  int         outcomes_checked;

  lpfc_item_if   item_ch ();
  lpfc_result_if result_ch ();

  length_prefixed_frame_checker_core uut (
    .clk            (clk),
    .rst            (rst),
    .item           (item_ch),
    .result         (result_ch),
    .cfg_write_en   (cfg_write_en),
    .cfg_write_data (cfg_write_data)
  );

  frame_outcome_checker checker_i (
    .clk              (clk),
    .rst              (rst),
    .item_valid       (item_ch.valid),
    .item_ready       (item_ch.ready),
    .item_mode        (item_ch.mode),
    .item_byte        (item_ch.byte_value),
    .result_valid     (result_ch.valid),
    .result_ready     (result_ch.ready),
    .result_status    (result_ch.status),
    .result_length    (result_ch.frame_length),
    .cfg_write_en     (cfg_write_en),
    .cfg_write_data   (cfg_write_data),
    .mismatch_count   (mismatch_count),
    .outcomes_pending (outcomes_pending),
    .outcomes_checked (outcomes_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    cycle_count = 0;
    while (cycle_count < RUN_CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Result sink: random stalls, plus a long hold-off on request
  initial begin : result_sink
    int hold_left;
    hold_left       = 0;
    result_ch.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst) begin
        result_ch.ready <= 1'b0;
      end else if (hold_go) begin
        hold_left = HOLD_CYCLES;
        result_ch.ready <= 1'b0;
      end else if (hold_left != 0) begin
        hold_left--;
        result_ch.ready <= 1'b0;
      end else begin
        result_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  // Offer one word, with random idle cycles first; return once it is taken
  task automatic send_word(input mode_t m, input logic [7:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      item_ch.valid <= 1'b0;
      @(posedge clk);
    end
    item_ch.valid      <= 1'b1;
    item_ch.mode       <= m;
    item_ch.byte_value <= b;
    do @(posedge clk); while (!item_ch.ready);
    words_sent++;
  endtask

  task automatic send_ticks(input int n);
    repeat (n) send_word(MODE_TICK, 8'($urandom));
  endtask

  // Hold the sender until every predicted outcome has been delivered
  task automatic drain();
    item_ch.valid <= 1'b0;
    repeat (2) @(posedge clk);
    while (outcomes_pending != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_ticks_per_byte(input logic [7:0] v);
    cfg_write_en   <= 1'b1;
    cfg_write_data <= v;
    @(posedge clk);
    cfg_write_en   <= 1'b0;
    @(posedge clk);
    cfg_writes++;
  endtask

  // One random sequence: mostly well-formed frames, some noise and broken frames
  task automatic send_random_sequence(input logic [7:0] tpb);
    int         kind;
    int         len;
    int         limit;
    int         cut;
    int         timeout_at;
    int         spread;
    int         k;
    logic       on_boundary;
    logic [7:0] sum;
    logic [7:0] data;
    kind = $urandom_range(99);
    if (kind < 8) begin
      send_word(MODE_BYTE, EMPTY_LENGTH);
    end else if (kind < 13) begin
      send_word(MODE_BYTE, SINGLE_LENGTH);
    end else if (kind < 23) begin
      repeat ($urandom_range(1, 5)) send_word(mode_t'($urandom_range(1)), 8'($urandom));
    end else begin
      len         = ($urandom_range(99) < 3) ? $urandom_range(200, 255) : $urandom_range(2, 12);
      limit       = tpb * len;
      cut         = (kind < 30) ? $urandom_range(1, len - 1) : len;
      timeout_at  = (kind >= 30 && kind < 40 && limit <= 40) ? $urandom_range(1, len - 1) : 0;
      on_boundary = (kind >= 40 && kind < 48 && limit <= 40);
      spread      = (tpb < 2) ? tpb : 2;
      sum         = 8'(len);
      send_word(MODE_BYTE, 8'(len));
      for (k = 1; k < cut; k++) begin
        // Ticks: past the limit, exactly at it, or well inside it
        if (k == timeout_at) begin
          send_ticks(limit + 1);
        end else if (on_boundary) begin
          if (k == len - 1) send_ticks(limit);
        end else if ($urandom_range(3) == 0) begin
          send_ticks($urandom_range(0, spread));
        end
        if (k == len - 1) begin
          data = ($urandom_range(9) == 0) ? (sum ^ 8'($urandom_range(1, 255))) : sum;
        end else begin
          data = 8'($urandom);
        end
        sum = sum + data;
        send_word(MODE_BYTE, data);
      end
    end
  endtask

  // Stimulus and verdict
  initial begin : stimulus
    logic [7:0] tpb_list [6];
    logic [7:0] tpb;
    int         phase;
    int         phase_start;
    rst                = 1'b1;
    cfg_write_en       = 1'b0;
    cfg_write_data     = '0;
    hold_go            = 1'b0;
    item_ch.valid      = 1'b0;
    item_ch.mode       = MODE_BYTE;
    item_ch.byte_value = '0;
    send_idle_pct      = 0;
    recv_idle_pct      = 0;
    words_sent         = 0;
    cfg_writes         = 0;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty and single-word frames, idle tick, short frames, wrap
    send_word(MODE_BYTE, EMPTY_LENGTH);
    send_word(MODE_BYTE, SINGLE_LENGTH);
    send_word(MODE_TICK, 8'hFF);
    send_word(MODE_BYTE, 8'd2);
    send_word(MODE_BYTE, 8'd2);
    send_word(MODE_BYTE, 8'd2);
    send_word(MODE_BYTE, 8'd3);
    send_word(MODE_BYTE, 8'd3);
    send_word(MODE_BYTE, 8'hFF);
    send_word(MODE_BYTE, 8'h02);
    drain();
    // Directed: zero allowance times out on the first tick
    write_ticks_per_byte(8'd0);
    send_word(MODE_BYTE, 8'd2);
    send_word(MODE_TICK, 8'h00);
    drain();
    // Directed: ticks right at the limit pass, one more times out
    write_ticks_per_byte(8'd1);
    send_word(MODE_BYTE, 8'd3);
    send_ticks(3);
    send_word(MODE_BYTE, 8'h80);
    send_word(MODE_BYTE, 8'h83);
    send_word(MODE_BYTE, 8'd2);
    send_ticks(3);
    drain();

    // Random phases over several allowances and idling patterns
    tpb_list = '{8'd255, 8'd2, 8'd0, 8'd1, 8'($urandom), 8'd3};
    for (phase = 0; phase < 6; phase++) begin
      tpb = tpb_list[phase];
      write_ticks_per_byte(tpb);
      case (phase / 2)
        0: begin
          send_idle_pct = 15;
          recv_idle_pct <= 63;
        end
        1: begin
          send_idle_pct = 63;
          recv_idle_pct <= 15;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct <= 0;
        end
      endcase
      // Hold off the sink while words keep coming, so the input stalls
      if (phase == 4) begin
        hold_go <= 1'b1;
        @(posedge clk);
        hold_go <= 1'b0;
      end
      phase_start = words_sent;
      while (words_sent - phase_start < WORDS_PER_PHASE) begin
        send_random_sequence(tpb);
        if ($urandom_range(39) == 0) drain();
      end
      drain();
    end

    $display("Sent %0d words over %0d allowance settings; %0d frame outcomes checked.",
             words_sent, cfg_writes, outcomes_checked);
    $display("Mismatches: %0d, outcomes still outstanding: %0d.", mismatch_count,
             outcomes_pending);
    if (mismatch_count == 0 && outcomes_pending == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
